>>> rtl/core/ista_sparse_recovery_solver_assert.svh
// Assertion macros for the sparse recovery solver checker.
`ifndef ISTA_SPARSE_RECOVERY_SOLVER_ASSERT_SVH
`define ISTA_SPARSE_RECOVERY_SOLVER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define ISRS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ISRS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/isrs_pkg.sv
package isrs_pkg;

	localparam int ROWS_DEF = 32;
	localparam int COLS_DEF = 32;

	localparam logic [1:0] CMD_LOAD_A = 2'd0;
	localparam logic [1:0] CMD_LOAD_Y = 2'd1;
	localparam logic [1:0] CMD_START  = 2'd2;

	localparam logic [1:0] REG_LAMBDA = 2'd0;
	localparam logic [1:0] REG_MU     = 2'd1;
	localparam logic [1:0] REG_ITERS  = 2'd2;

	localparam logic signed [31:0] LAMBDA_RST = 32'sd0;
	localparam logic signed [31:0] MU_RST     = 32'sd655;
	localparam logic [15:0]        ITERS_RST  = 16'd100;

	typedef enum logic [18:0] {
		S_IDLE   = 19'b000_0000_0000_0000_0001,
		S_CLR    = 19'b000_0000_0000_0000_0010,
		S_R_RD   = 19'b000_0000_0000_0000_0100,
		S_R_MUL  = 19'b000_0000_0000_0000_1000,
		S_R_ACC  = 19'b000_0000_0000_0001_0000,
		S_R_SUM  = 19'b000_0000_0000_0010_0000,
		S_R_SUB  = 19'b000_0000_0000_0100_0000,
		S_G_RD   = 19'b000_0000_0000_1000_0000,
		S_G_MUL  = 19'b000_0000_0001_0000_0000,
		S_G_ACC  = 19'b000_0000_0010_0000_0000,
		S_T_MUL  = 19'b000_0000_0100_0000_0000,
		S_T_ACC  = 19'b000_0000_1000_0000_0000,
		S_U_RD   = 19'b000_0001_0000_0000_0000,
		S_U_MUL  = 19'b000_0010_0000_0000_0000,
		S_U_ACC  = 19'b000_0100_0000_0000_0000,
		S_U_THR  = 19'b000_1000_0000_0000_0000,
		S_O_RD   = 19'b001_0000_0000_0000_0000,
		S_O_LD   = 19'b010_0000_0000_0000_0000,
		S_O_WAIT = 19'b100_0000_0000_0000_0000
	} isrs_state_t;

	function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
		logic signed [31:0] r;
		if (v > 49'sd2147483647)
			r = 32'h7fff_ffff;
		else if (v < -49'sd2147483648)
			r = 32'h8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	// a + p with p carrying 32 fraction bits, rounded to nearest (ties up)
	function automatic logic signed [31:0] round_sat(input logic signed [31:0] a,
			input logic signed [63:0] p);
		logic signed [64:0] s;
		logic signed [48:0] q;
		s = (65'(a) <<< 16) + 65'(p) + 65'sd32768;
		q = 49'(s >>> 16);
		return sat32(q);
	endfunction

endpackage

>>> rtl/core/ista_sparse_recovery_solver.sv
// ISTA sparse recovery solver. Load words (command 0: matrix entry at row/col, command 1:
// measurement entry at row) give no output; out-of-range indexes are dropped. A start
// word clears the estimate and then runs iteration_count iterations on one shared 32x32
// multiplier with a rounding accumulator behind it; each multiply-accumulate passes a
// memory read, a multiply and an accumulate step, but the threshold product has no read.
// The COLS solution words leave one at a time, each held until taken, last set on the
// final one. Input is stalled from the start word until the final solution word is taken.
// Configuration must be written only while idle; the block does not enforce this. All
// values are signed 16.16, rounded to nearest and saturated when stored.
module ista_sparse_recovery_solver
	import isrs_pkg::*;
#(
	parameter int ROWS = ROWS_DEF,
	parameter int COLS = COLS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic [4:0]         row,
	input  logic [4:0]         col,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [4:0]         index,
	output logic signed [31:0] x_value,
	output logic               last
);

	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW = $clog2(COLS);
	localparam int AW = $clog2(ROWS * COLS);

	isrs_state_t state_q;

	logic signed [31:0] lambda_q, mu_q;
	logic [15:0]        iters_q, it_q;
	logic [RW-1:0]      i_q;
	logic [CW-1:0]      j_q;
	logic [2:0]         k_q;

	logic signed [31:0] a_mem [ROWS*COLS];
	logic signed [31:0] y_mem [ROWS];
	logic signed [31:0] x_mem [COLS];
	logic signed [31:0] r_mem [ROWS];
	logic signed [31:0] g_mem [COLS];
	logic signed [31:0] a_rd_q, y_rd_q, x_rd_q, r_rd_q, g_rd_q;

	logic signed [31:0] part_q [8];
	logic signed [31:0] total_q, t_q, v_q;
	logic signed [63:0] prod_s1;

	logic               in_acc, out_acc, j_last, i_last, it_last;
	logic [AW-1:0]      a_addr, ld_addr;
	logic signed [31:0] mul_b, mul_c, mac_a, mac_res;
	logic signed [31:0] add_a, add_b, add_res;
	logic               add_sub;
	logic signed [32:0] v_ext, t_ext;
	logic signed [31:0] thr_res;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;
	assign j_last   = (j_q == CW'(COLS - 1));
	assign i_last   = (i_q == RW'(ROWS - 1));
	assign it_last  = ((it_q + 16'd1) == iters_q);
	assign a_addr   = AW'(32'(i_q) * COLS + 32'(j_q));
	assign ld_addr  = AW'(32'(row) * COLS + 32'(col));

	// shared multiplier operands
	always_comb begin
		mul_b = a_rd_q;
		mul_c = x_rd_q;
		mac_a = '0;
		case (state_q)
			S_R_MUL, S_R_ACC: begin
				mul_c = x_rd_q;
				mac_a = ((j_q >> 3) == '0) ? 32'sd0 : part_q[j_q[2:0]];
			end
			S_G_MUL, S_G_ACC: begin
				mul_c = r_rd_q;
				mac_a = (i_q == '0) ? 32'sd0 : g_rd_q;
			end
			S_T_MUL, S_T_ACC: begin
				mul_b = mu_q;
				mul_c = lambda_q;
			end
			S_U_MUL, S_U_ACC: begin
				mul_b = mu_q;
				mul_c = g_rd_q;
				mac_a = x_rd_q;
			end
			default: ;
		endcase
	end

	assign mac_res = round_sat(mac_a, prod_s1);

	// shared saturating adder
	always_comb begin
		add_a   = total_q;
		add_b   = part_q[k_q];
		add_sub = 1'b0;
		case (state_q)
			S_R_SUM: begin
				add_a = (k_q == '0) ? 32'sd0 : total_q;
				add_b = part_q[k_q];
			end
			S_R_SUB: begin
				add_a   = y_rd_q;
				add_b   = total_q;
				add_sub = 1'b1;
			end
			default: ;
		endcase
		add_res = sat32(add_sub ? 49'(add_a) - 49'(add_b) : 49'(add_a) + 49'(add_b));
	end

	// soft threshold; the first comparison wins for a negative threshold
	always_comb begin
		v_ext = 33'(v_q);
		t_ext = 33'(t_q);
		if (v_ext > t_ext)
			thr_res = sat32(49'(v_q) - 49'(t_q));
		else if (v_ext < -t_ext)
			thr_res = sat32(49'(v_q) + 49'(t_q));
		else
			thr_res = '0;
	end

	// memories: registered reads every cycle at the current counters
	always_ff @(posedge clk) begin
		a_rd_q <= a_mem[a_addr];
		y_rd_q <= y_mem[i_q];
		x_rd_q <= x_mem[j_q];
		r_rd_q <= r_mem[i_q];
		g_rd_q <= g_mem[j_q];
		if (in_acc && command == CMD_LOAD_A && 9'(row) < 9'(ROWS) && 7'(col) < 7'(COLS))
			a_mem[ld_addr] <= value;
		if (in_acc && command == CMD_LOAD_Y && 9'(row) < 9'(ROWS))
			y_mem[RW'(row)] <= value;
		if (state_q == S_CLR)
			x_mem[j_q] <= '0;
		else if (state_q == S_U_THR)
			x_mem[j_q] <= thr_res;
		if (state_q == S_R_SUB)
			r_mem[i_q] <= add_res;
		if (state_q == S_G_ACC)
			g_mem[j_q] <= mac_res;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_s1 <= 64'(mul_b) * 64'(mul_c);
		if (state_q == S_R_ACC)
			part_q[j_q[2:0]] <= mac_res;
		if (state_q == S_R_SUM)
			total_q <= add_res;
		if (state_q == S_T_ACC)
			t_q <= mac_res;
		if (state_q == S_U_ACC)
			v_q <= mac_res;
		if (state_q == S_O_LD) begin
			index   <= 5'(j_q);
			x_value <= x_rd_q;
			last    <= j_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lambda_q <= LAMBDA_RST;
			mu_q     <= MU_RST;
			iters_q  <= ITERS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LAMBDA: lambda_q <= cfg_data;
				REG_MU:     mu_q     <= cfg_data;
				REG_ITERS:  iters_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			it_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc && command == CMD_START) begin
						j_q     <= '0;
						state_q <= S_CLR;
					end
				end
				S_CLR: begin
					if (j_last) begin
						i_q     <= '0;
						j_q     <= '0;
						it_q    <= '0;
						state_q <= (iters_q == '0) ? S_O_RD : S_R_RD;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_R_RD:  state_q <= S_R_MUL;
				S_R_MUL: state_q <= S_R_ACC;
				S_R_ACC: begin
					if (j_last) begin
						k_q     <= '0;
						state_q <= S_R_SUM;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_R_RD;
					end
				end
				S_R_SUM: begin
					k_q <= k_q + 1'b1;
					if (k_q == 3'd7)
						state_q <= S_R_SUB;
				end
				S_R_SUB: begin
					j_q     <= '0;
					state_q <= i_last ? S_G_RD : S_R_RD;
					i_q     <= i_last ? '0 : i_q + 1'b1;
				end
				S_G_RD:  state_q <= S_G_MUL;
				S_G_MUL: state_q <= S_G_ACC;
				S_G_ACC: begin
					if (j_last) begin
						j_q <= '0;
						if (i_last) begin
							state_q <= S_T_MUL;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_G_RD;
						end
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_G_RD;
					end
				end
				S_T_MUL: state_q <= S_T_ACC;
				S_T_ACC: begin
					j_q     <= '0;
					state_q <= S_U_RD;
				end
				S_U_RD:  state_q <= S_U_MUL;
				S_U_MUL: state_q <= S_U_ACC;
				S_U_ACC: state_q <= S_U_THR;
				S_U_THR: begin
					if (j_last) begin
						i_q <= '0;
						j_q <= '0;
						if (it_last) begin
							state_q <= S_O_RD;
						end else begin
							it_q    <= it_q + 16'd1;
							state_q <= S_R_RD;
						end
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_U_RD;
					end
				end
				S_O_RD: state_q <= S_O_LD;
				S_O_LD: begin
					out_valid <= 1'b1;
					state_q   <= S_O_WAIT;
				end
				S_O_WAIT: begin
					if (out_acc) begin
						out_valid <= 1'b0;
						if (j_last) begin
							state_q <= S_IDLE;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_O_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/isrs_checker.sv
`include "ista_sparse_recovery_solver_assert.svh"

module isrs_checker
	import isrs_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [1:0]         command,
	input logic               out_valid,
	input logic               out_stall,
	input logic [4:0]         index,
	input logic signed [31:0] x_value,
	input logic               last
);

	// a stalled result word holds
	`ISRS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(index) && $stable(x_value) && $stable(last), "stalled result word changed")

	// no input is taken while a result is pending
	`ISRS_ASSERT(a_busy_out, out_valid |-> in_stall, "input accepted with a result pending")

	// more results follow a non-final word, so input stays stalled
	`ISRS_ASSERT(a_busy_next, out_valid && !out_stall && !last |=> in_stall, "input open before final word")

	// a load gives no result
	`ISRS_ASSERT(a_load_quiet, in_valid && !in_stall && (command == CMD_LOAD_A || command == CMD_LOAD_Y) |=> !out_valid && !in_stall, "load produced a result")

endmodule

bind ista_sparse_recovery_solver isrs_checker u_isrs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.command  (command),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.index    (index),
	.x_value  (x_value),
	.last     (last)
);

>>> tb/ista_sparse_recovery_solver_tb.sv
module ista_sparse_recovery_solver_tb;
	import isrs_pkg::*;

	localparam int N = 32;
	localparam logic [1:0] CMD_IGNORED = 2'd3;
	localparam logic [1:0] REG_UNUSED  = 2'd3;
	localparam int MAX_POS = 32'h7fff_ffff;
	localparam int MAX_NEG = 32'h8000_0000;
	localparam int ONE     = 32'h0001_0000;

	typedef struct {
		logic [4:0] idx;
		int         xv;
		logic       lst;
	} sol_word_t;

	typedef struct {
		logic [1:0] cmd;
		logic [4:0] r;
		logic [4:0] c;
		int         v;
		bit         zeros;	// expected solution typed in: all zero
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = '0;
	logic [31:0]       cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        command = '0;
	logic [4:0]        row = '0;
	logic [4:0]        col = '0;
	logic signed [31:0] value = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [4:0]        index;
	logic signed [31:0] x_value;
	logic              last;

	ista_sparse_recovery_solver i_dut (.*);

	always #5 clk = ~clk;

	// model state
	int        a_mat [N][N];
	int        y_vec [N];
	int        x_est [N];
	int        lambda_w = LAMBDA_RST;
	int        mu_w = MU_RST;
	int        iters = ITERS_RST;
	sol_word_t solution_q [$];
	int        errors = 0;
	int        send_idle_pct = 21;
	int        recv_stall_pct = 65;

	function automatic int clip(longint v);
		if (v > longint'(MAX_POS))
			return MAX_POS;
		if (v < -64'sd2147483648)
			return MAX_NEG;
		return int'(v);
	endfunction

	// a + b*c with the product exact, rounded ties up, saturated
	function automatic int mac_round(int a, int b, int c);
		longint acc;
		acc = longint'(a) * 65536 + longint'(b) * longint'(c);
		return clip((acc + 32768) >>> 16);
	endfunction

	task automatic solve_estimate();
		int part [8];
		int res [N];
		int grad [N];
		int total, t, v;
		for (int j = 0; j < N; j++)
			x_est[j] = 0;
		for (int it = 0; it < iters; it++) begin
			for (int i = 0; i < N; i++) begin
				total = 0;
				for (int k = 0; k < 8; k++)
					part[k] = 0;
				for (int j = 0; j < N; j++)
					part[j & 7] = mac_round(part[j & 7], a_mat[i][j], x_est[j]);
				for (int k = 0; k < 8; k++)
					total = clip(longint'(total) + part[k]);
				res[i] = clip(longint'(y_vec[i]) - total);
			end
			for (int j = 0; j < N; j++)
				grad[j] = 0;
			for (int i = 0; i < N; i++)
				for (int j = 0; j < N; j++)
					grad[j] = mac_round(grad[j], a_mat[i][j], res[i]);
			t = mac_round(0, mu_w, lambda_w);
			for (int j = 0; j < N; j++) begin
				v = mac_round(x_est[j], mu_w, grad[j]);
				if (longint'(v) > longint'(t))
					x_est[j] = clip(longint'(v) - t);
				else if (longint'(v) < -longint'(t))
					x_est[j] = clip(longint'(v) + t);
				else
					x_est[j] = 0;
			end
		end
		for (int j = 0; j < N; j++)
			solution_q.push_back('{idx: 5'(j), xv: x_est[j], lst: (j == N - 1)});
	endtask

	task automatic apply_word(stim_row_t s);
		case (s.cmd)
			CMD_LOAD_A: a_mat[s.r][s.c] = s.v;
			CMD_LOAD_Y: y_vec[s.r] = s.v;
			CMD_START: begin
				if (s.zeros) begin
					for (int j = 0; j < N; j++) begin
						x_est[j] = 0;
						solution_q.push_back('{idx: 5'(j), xv: 0, lst: (j == N - 1)});
					end
				end else
					solve_estimate();
			end
			default: ;
		endcase
	endtask

	// called at a falling edge; returns at a falling edge
	task automatic send_word(stim_row_t s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		command = s.cmd;
		row = s.r;
		col = s.c;
		value = s.v;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		apply_word(s);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (solution_q.size() != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_LAMBDA: lambda_w = int'(data);
			REG_MU:     mu_w = int'(data);
			REG_ITERS:  iters = int'(data[15:0]);
			default: ;
		endcase
	endtask

	function automatic int rand_value();
		case ($urandom_range(4))
			0: return int'($urandom);
			1: return $signed($urandom_range(2 * ONE)) - ONE;
			2: return $signed($urandom_range(8192)) - 4096;
			3: return ($urandom_range(1)) ? MAX_POS : MAX_NEG;
			default: return $signed($urandom_range(ONE / 2)) - ONE / 4;
		endcase
	endfunction

	function automatic stim_row_t rand_row(bit with_start);
		stim_row_t s;
		int pick;
		pick = $urandom_range(99);
		s.r = 5'($urandom);
		s.c = 5'($urandom);
		s.v = rand_value();
		s.zeros = 1'b0;
		if (pick < 60)
			s.cmd = CMD_LOAD_A;
		else if (pick < 90)
			s.cmd = CMD_LOAD_Y;
		else
			s.cmd = CMD_IGNORED;
		if (with_start)
			s.cmd = CMD_START;
		return s;
	endfunction

	// receiver stall
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		sol_word_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (solution_q.size() == 0) begin
				$error("solution word with nothing expected: index %0d", index);
				errors++;
			end else begin
				e = solution_q.pop_front();
				if (index !== e.idx) begin
					$error("index: expected %0d, got %0d", e.idx, index);
					errors++;
				end
				if (x_value !== e.xv) begin
					$error("x_value: expected %0d, got %0d", e.xv, x_value);
					errors++;
				end
				if (last !== e.lst) begin
					$error("last: expected %0d, got %0d", e.lst, last);
					errors++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("ista_sparse_recovery_solver_tb failed");
		$finish;
	end

	stim_row_t directed [] = '{
		'{CMD_START,   5'd0,  5'd0,  0,        1'b1},
		'{CMD_LOAD_A,  5'd0,  5'd0,  MAX_POS,  1'b0},
		'{CMD_LOAD_A,  5'd31, 5'd31, MAX_NEG,  1'b0},
		'{CMD_LOAD_A,  5'd0,  5'd31, -1,       1'b0},
		'{CMD_LOAD_A,  5'd31, 5'd0,  0,        1'b0},
		'{CMD_LOAD_Y,  5'd0,  5'd17, MAX_NEG,  1'b0},
		'{CMD_LOAD_Y,  5'd31, 5'd0,  MAX_POS,  1'b0},
		'{CMD_IGNORED, 5'd31, 5'd31, -1,       1'b0},
		'{CMD_IGNORED, 5'd0,  5'd0,  0,        1'b0},
		'{CMD_START,   5'd31, 5'd31, -1,       1'b1}
	};

	initial begin
		int lam_set [6] = '{0, MAX_POS, MAX_NEG, 3277, -6554, 0};
		int mu_set  [6] = '{MU_RST, MAX_POS, MAX_NEG, 16384, 4096, 32768};
		int it_set  [6] = '{1, 1, 1, 2, 1, 1};
		stim_row_t s;
		int phase_items;

		for (int i = 0; i < N; i++) begin
			y_vec[i] = 0;
			x_est[i] = 0;
			for (int j = 0; j < N; j++)
				a_mat[i][j] = 0;
		end
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// zero iterations: the cleared estimate comes straight out
		write_reg(REG_ITERS, 32'd0);
		foreach (directed[k])
			send_word(directed[k]);
		drain();

		// fill every entry before any iteration reads the stores
		for (int i = 0; i < N; i++) begin
			for (int j = 0; j < N; j++)
				send_word('{CMD_LOAD_A, 5'(i), 5'(j),
					$signed($urandom_range(ONE / 2)) - ONE / 4, 1'b0});
			send_word('{CMD_LOAD_Y, 5'(i), 5'd0, rand_value(), 1'b0});
		end

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			write_reg(REG_LAMBDA, lam_set[ph]);
			write_reg(REG_MU, mu_set[ph]);
			write_reg(REG_ITERS, it_set[ph]);
			if (ph == 5) begin
				write_reg(REG_UNUSED, 32'hffff_ffff);
				write_reg(REG_ITERS, 32'hffff_0000);
			end
			case (ph)
				0, 1: begin send_idle_pct = 21; recv_stall_pct = 65; end
				2, 3: begin send_idle_pct = 65; recv_stall_pct = 21; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			phase_items = 45;
			for (int k = 0; k < phase_items; k++) begin
				s = rand_row(k == 20 || k == phase_items - 1);
				// hold the next start until the previous solution is out
				if (k == 20 && ph == 3)
					drain();
				send_word(s);
			end
		end

		drain();
		if (errors == 0)
			$display("ista_sparse_recovery_solver_tb passed");
		else
			$display("ista_sparse_recovery_solver_tb failed");
		$finish;
	end

endmodule
